/* src/char_lcd_4bit_write_sequencer_macros.svh */
// Assertion helpers used by the sequencer's back stage (lcdw_back).
`ifndef CHAR_LCD_4BIT_WRITE_SEQUENCER_MACROS_SVH
`define CHAR_LCD_4BIT_WRITE_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LCDW_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lcdw: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define LCDW_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lcdw: next-cycle check failed");

`endif

/* src/lcdw_pkg.sv */
package lcdw_pkg;

   localparam int LCDW_QUEUE_DEPTH = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [2:0] ACT_TICK    = 3'd0;
   localparam logic [2:0] ACT_COMMAND = 3'd1;
   localparam logic [2:0] ACT_DATA    = 3'd2;
   localparam logic [2:0] ACT_CURSOR  = 3'd3;
   localparam logic [2:0] ACT_INIT    = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE_HIGH = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE_GAP  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SETTLE      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLEAR_EXTRA = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_POWER_UP    = 3'd4;

   localparam logic [7:0]  RST_ENABLE_HIGH = 8'd1;
   localparam logic [9:0]  RST_ENABLE_GAP  = 10'd50;
   localparam logic [15:0] RST_SETTLE      = 16'd1000;
   localparam logic [15:0] RST_CLEAR_EXTRA = 16'd2000;
   localparam logic [15:0] RST_POWER_UP    = 16'd50000;

   localparam logic [7:0] CLEAR_CMD   = 8'h01;
   localparam logic [7:0] CURSOR_CMD  = 8'h80;
   localparam logic [6:0] ROW2_OFFSET = 7'h40;
   localparam logic [2:0] INIT_LEN    = 3'd7;
   localparam logic [2:0] CLEAR_STEP  = 3'd4;

   // Positions of the per-byte wait slots, in the order a byte walks through them.
   localparam logic [2:0] POS_HI_EN  = 3'd0;
   localparam logic [2:0] POS_HI_GP  = 3'd1;
   localparam logic [2:0] POS_LO_EN  = 3'd2;
   localparam logic [2:0] POS_LO_GP  = 3'd3;
   localparam logic [2:0] POS_SETTLE = 3'd4;
   localparam logic [2:0] POS_CLEAR  = 3'd5;
   localparam logic [2:0] POS_DONE   = 3'd6;
   localparam int SLOT_COUNT = 6;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_POWER,
      PH_HI_EN,
      PH_HI_GP,
      PH_LO_EN,
      PH_LO_GP,
      PH_SETTLE,
      PH_CLEAR
   } lcdw_phase_type;

   typedef enum logic [1:0] {
      KIND_NOP,
      KIND_TICK,
      KIND_BYTE,
      KIND_INIT
   } lcdw_kind_type;

   typedef struct packed {
      logic       rs;
      logic       en;
      logic [3:0] nib;
   } lcdw_pins_type;

   typedef struct packed {
      logic [7:0]  enable_high_us;
      logic [9:0]  enable_gap_us;
      logic [15:0] settle_us;
      logic [15:0] clear_extra_us;
      logic [15:0] power_up_us;
   } lcdw_cfg_type;

   typedef struct packed {
      lcdw_phase_type phase;
      logic [15:0]    wait_cnt;
      logic [7:0]     byte_val;
      logic           rs;
      logic [2:0]     step;
      logic           init;
      lcdw_pins_type  pins;
   } lcdw_state_type;

   typedef struct packed {
      lcdw_kind_type kind;
      logic [7:0]    byte_val;
      logic          rs;
   } lcdw_item_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } lcdw_queue_status_type;

   typedef struct packed {
      lcdw_pins_type pins;
      logic          busy;
      logic          rejected;
   } lcdw_result_type;

   function automatic logic [7:0] init_byte(input logic [2:0] n);
      logic [7:0] b;
      case (n)
         3'd0:    b = 8'h33;
         3'd1:    b = 8'h32;
         3'd2:    b = 8'h28;
         3'd3:    b = 8'h08;
         3'd4:    b = 8'h01;
         3'd5:    b = 8'h06;
         3'd6:    b = 8'h0C;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic lcdw_phase_type phase_at(input logic [2:0] pos);
      lcdw_phase_type p;
      case (pos)
         POS_HI_EN:  p = PH_HI_EN;
         POS_HI_GP:  p = PH_HI_GP;
         POS_LO_EN:  p = PH_LO_EN;
         POS_LO_GP:  p = PH_LO_GP;
         POS_SETTLE: p = PH_SETTLE;
         POS_CLEAR:  p = PH_CLEAR;
         default:    p = PH_IDLE;
      endcase
      return p;
   endfunction

   function automatic logic [2:0] pos_of(input lcdw_phase_type p);
      logic [2:0] pos;
      case (p)
         PH_HI_EN:  pos = POS_HI_EN;
         PH_HI_GP:  pos = POS_HI_GP;
         PH_LO_EN:  pos = POS_LO_EN;
         PH_LO_GP:  pos = POS_LO_GP;
         PH_SETTLE: pos = POS_SETTLE;
         PH_CLEAR:  pos = POS_CLEAR;
         default:   pos = POS_DONE;
      endcase
      return pos;
   endfunction

   function automatic logic [15:0] wait_for(input lcdw_phase_type p, input lcdw_cfg_type cfg);
      logic [15:0] w;
      case (p)
         PH_HI_EN, PH_LO_EN: w = {8'd0, cfg.enable_high_us};
         PH_HI_GP, PH_LO_GP: w = {6'd0, cfg.enable_gap_us};
         PH_SETTLE:          w = cfg.settle_us;
         PH_CLEAR:           w = cfg.clear_extra_us;
         PH_POWER:           w = cfg.power_up_us;
         default:            w = 16'd0;
      endcase
      return w;
   endfunction

   // Pin levels once a byte has reached the given phase; the low-nibble
   // levels hold through the settle and clear waits.
   function automatic lcdw_pins_type pins_for(input lcdw_phase_type p, input logic [7:0] b,
                                              input logic rs);
      lcdw_pins_type q;
      case (p)
         PH_HI_EN: q = '{rs: rs, en: 1'b1, nib: b[7:4]};
         PH_HI_GP: q = '{rs: rs, en: 1'b0, nib: b[7:4]};
         PH_LO_EN: q = '{rs: rs, en: 1'b1, nib: b[3:0]};
         default:  q = '{rs: rs, en: 1'b0, nib: b[3:0]};
      endcase
      return q;
   endfunction

   // First wait slot at or after start whose length is not zero; PH_IDLE when
   // every remaining slot of the byte is empty and the byte is finished.
   function automatic lcdw_phase_type land(input logic [2:0] start, input logic clr,
                                           input lcdw_cfg_type cfg);
      logic [SLOT_COUNT-1:0] live;
      lcdw_phase_type        l;
      logic                  found;
      live = {clr && (cfg.clear_extra_us != 16'd0), cfg.settle_us != 16'd0,
              cfg.enable_gap_us != 10'd0, cfg.enable_high_us != 8'd0,
              cfg.enable_gap_us != 10'd0, cfg.enable_high_us != 8'd0};
      l = PH_IDLE;
      found = 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (!found && (3'(i) >= start) && live[i]) begin
            l = phase_at(3'(i));
            found = 1'b1;
         end
      end
      return l;
   endfunction

   // Start init byte n. If the byte passes with no wait at all, every enable
   // and settle wait is zero, so the rest of the sequence passes too, except
   // that a nonzero clear wait still stops on the clear command.
   function automatic lcdw_state_type start_init_byte(input logic [2:0] n,
                                                      input lcdw_cfg_type cfg);
      lcdw_state_type s;
      lcdw_phase_type l;
      s.byte_val = init_byte(n);
      s.rs = 1'b0;
      s.step = n;
      s.init = 1'b1;
      l = land(POS_HI_EN, s.byte_val == CLEAR_CMD, cfg);
      if (l != PH_IDLE) begin
         s.phase = l;
         s.wait_cnt = wait_for(l, cfg);
         s.pins = pins_for(l, s.byte_val, 1'b0);
      end else if ((n < CLEAR_STEP) && (cfg.clear_extra_us != 16'd0)) begin
         s.phase = PH_CLEAR;
         s.step = CLEAR_STEP;
         s.byte_val = CLEAR_CMD;
         s.wait_cnt = cfg.clear_extra_us;
         s.pins = pins_for(PH_CLEAR, CLEAR_CMD, 1'b0);
      end else begin
         s.phase = PH_IDLE;
         s.step = INIT_LEN;
         s.init = 1'b0;
         s.byte_val = init_byte(INIT_LEN - 3'd1);
         s.wait_cnt = 16'd0;
         s.pins = pins_for(PH_LO_GP, s.byte_val, 1'b0);
      end
      return s;
   endfunction

   // Continue the current byte from slot start, finishing it and moving on to
   // the next init byte as the waits run out.
   function automatic lcdw_state_type run_from(input logic [2:0] start,
                                               input lcdw_state_type cur,
                                               input lcdw_cfg_type cfg);
      lcdw_state_type s;
      lcdw_phase_type l;
      s = cur;
      l = land(start, !cur.rs && (cur.byte_val == CLEAR_CMD), cfg);
      if (l != PH_IDLE) begin
         s.phase = l;
         s.wait_cnt = wait_for(l, cfg);
         s.pins = pins_for(l, cur.byte_val, cur.rs);
      end else if (cur.init && (cur.step < INIT_LEN - 3'd1)) begin
         s = start_init_byte(cur.step + 3'd1, cfg);
      end else begin
         s.phase = PH_IDLE;
         s.wait_cnt = 16'd0;
         s.pins = pins_for(PH_LO_GP, cur.byte_val, cur.rs);
         if (cur.init) begin
            s.init = 1'b0;
            s.step = cur.step + 3'd1;
         end
      end
      return s;
   endfunction

endpackage

/* src/lcdw_if.sv */
interface lcdw_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic [7:0] byte_value;
   logic       row;
   logic [5:0] col;

   modport source (output valid, action, byte_value, row, col, input ready);
   modport sink (input valid, action, byte_value, row, col, output ready);
endinterface

interface lcdw_rsp_if;
   logic       valid;
   logic       ready;
   logic       rs_pin;
   logic       enable_pin;
   logic [3:0] bus_nibble;
   logic       busy_res;
   logic       rejected;

   modport source (output valid, rs_pin, enable_pin, bus_nibble, busy_res, rejected,
                   input ready);
   modport sink (input valid, rs_pin, enable_pin, bus_nibble, busy_res, rejected,
                 output ready);
endinterface

/* src/char_lcd_4bit_write_sequencer.sv */
// Flow: an accepted item is written into the queue and popped by the back stage, whose
// result register holds its outcome until the output side takes it.
// Throughput: one item per clock; the queue and the output register let either side stall.
// Every item is settled by the back stage as it is popped, zero-length waits included.
// Reset (synchronous): empties the queue, returns the display state to idle with all pins
// low, drops any pending result and restores the default timing registers.
module char_lcd_4bit_write_sequencer
   import lcdw_pkg::*;
#(
   parameter int QUEUE_DEPTH = LCDW_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   lcdw_req_if.sink               req_port,
   lcdw_rsp_if.source             rsp_port,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   lcdw_queue_status_type q_status;
   lcdw_item_type         push_item;
   lcdw_item_type         head_item;
   logic                  push;
   logic                  pop;

   lcdw_front u_front (
      .req_port  (req_port),
      .q_status  (q_status),
      .push      (push),
      .push_item (push_item)
   );

   lcdw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .status    (q_status)
   );

   lcdw_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_item    (head_item),
      .q_status     (q_status),
      .pop          (pop),
      .rsp_port     (rsp_port),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

endmodule

/* src/lcdw_front.sv */
module lcdw_front
   import lcdw_pkg::*;
(
   lcdw_req_if.sink              req_port,
   input  lcdw_queue_status_type q_status,
   output logic                  push,
   output lcdw_item_type         push_item
);

   logic [6:0] cursor_addr;

   assign req_port.ready = !q_status.full;
   assign push = req_port.valid && !q_status.full;

   // Second display line starts at address 0x40.
   assign cursor_addr = {1'b0, req_port.col} + (req_port.row ? ROW2_OFFSET : 7'd0);

   always_comb begin
      push_item = '{kind: KIND_NOP, byte_val: req_port.byte_value, rs: 1'b0};
      unique case (req_port.action)
         ACT_TICK: push_item.kind = KIND_TICK;
         ACT_COMMAND: push_item.kind = KIND_BYTE;
         ACT_DATA: begin
            push_item.kind = KIND_BYTE;
            push_item.rs = 1'b1;
         end
         ACT_CURSOR: begin
            push_item.kind = KIND_BYTE;
            push_item.byte_val = CURSOR_CMD | {1'b0, cursor_addr};
         end
         ACT_INIT: push_item.kind = KIND_INIT;
         default: push_item.kind = KIND_NOP;
      endcase
   end

endmodule

/* src/lcdw_queue.sv */
module lcdw_queue
   import lcdw_pkg::*;
#(
   parameter int DEPTH = LCDW_QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  lcdw_item_type         push_item,
   input  logic                  pop,
   output lcdw_item_type         head_item,
   output lcdw_queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   lcdw_item_type    entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign status.full = (count_ff == CNT_W'(DEPTH));
   assign status.not_empty = (count_ff != '0);
   assign head_item = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* src/lcdw_back.sv */
`include "char_lcd_4bit_write_sequencer_macros.svh"

module lcdw_back
   import lcdw_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  lcdw_item_type          head_item,
   input  lcdw_queue_status_type  q_status,
   output logic                   pop,
   lcdw_rsp_if.source             rsp_port,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   lcdw_cfg_type    cfg_ff, cfg_in;
   lcdw_state_type  state_ff, state_in;
   lcdw_result_type rsp_data_ff, rsp_data_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            busy;
   logic            rej;
   lcdw_state_type  byte_start;

   assign pop = q_status.not_empty && (!rsp_valid_ff || rsp_port.ready);
   assign busy = (state_ff.phase != PH_IDLE);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_ENABLE_HIGH: cfg_in.enable_high_us = csr_wdata[7:0];
            CSR_ENABLE_GAP:  cfg_in.enable_gap_us = csr_wdata[9:0];
            CSR_SETTLE:      cfg_in.settle_us = csr_wdata;
            CSR_CLEAR_EXTRA: cfg_in.clear_extra_us = csr_wdata;
            CSR_POWER_UP:    cfg_in.power_up_us = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      byte_start = state_ff;
      byte_start.byte_val = head_item.byte_val;
      byte_start.rs = head_item.rs;
   end

   // One item per cycle unless stalled: a tick counts down or walks
   // to the next nonzero wait; an idle request starts a byte or power-up.
   always_comb begin
      state_in = state_ff;
      rej = 1'b0;
      if (pop) begin
         case (head_item.kind)
            KIND_TICK: begin
               if (busy) begin
                  if (state_ff.wait_cnt > 16'd1) begin
                     state_in.wait_cnt = state_ff.wait_cnt - 16'd1;
                  end else if (state_ff.phase == PH_POWER) begin
                     state_in = start_init_byte(3'd0, cfg_ff);
                  end else begin
                     state_in = run_from(pos_of(state_ff.phase) + 3'd1, state_ff, cfg_ff);
                  end
               end
            end
            KIND_BYTE: begin
               if (busy) begin
                  rej = 1'b1;
               end else begin
                  state_in = run_from(POS_HI_EN, byte_start, cfg_ff);
               end
            end
            KIND_INIT: begin
               if (busy) begin
                  rej = 1'b1;
               end else if (cfg_ff.power_up_us != 16'd0) begin
                  state_in.phase = PH_POWER;
                  state_in.wait_cnt = cfg_ff.power_up_us;
                  state_in.init = 1'b1;
                  state_in.step = 3'd0;
               end else begin
                  state_in = start_init_byte(3'd0, cfg_ff);
               end
            end
            default: state_in = state_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = pop || (rsp_valid_ff && !rsp_port.ready);
      rsp_data_in = rsp_data_ff;
      if (pop) begin
         rsp_data_in.pins = state_in.pins;
         rsp_data_in.busy = (state_in.phase != PH_IDLE);
         rsp_data_in.rejected = rej;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{enable_high_us: RST_ENABLE_HIGH, enable_gap_us: RST_ENABLE_GAP,
                     settle_us: RST_SETTLE, clear_extra_us: RST_CLEAR_EXTRA,
                     power_up_us: RST_POWER_UP};
         state_ff <= '{phase: PH_IDLE, wait_cnt: 16'd0, byte_val: 8'd0, rs: 1'b0,
                       step: 3'd0, init: 1'b0, pins: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.rs_pin = rsp_data_ff.pins.rs;
   assign rsp_port.enable_pin = rsp_data_ff.pins.en;
   assign rsp_port.bus_nibble = rsp_data_ff.pins.nib;
   assign rsp_port.busy_res = rsp_data_ff.busy;
   assign rsp_port.rejected = rsp_data_ff.rejected;

   `LCDW_ASSERT_IMPL(a_busy_wait_live, state_ff.phase != PH_IDLE, state_ff.wait_cnt != 16'd0)
   `LCDW_ASSERT_IMPL(a_init_step_range, state_ff.init, state_ff.step < INIT_LEN)
   `LCDW_ASSERT_IMPL(a_clear_only_cmd, state_ff.phase == PH_CLEAR, (state_ff.byte_val == CLEAR_CMD) && !state_ff.rs)
   `LCDW_ASSERT_NEXT(a_pop_gives_rsp, pop, rsp_valid_ff)

endmodule

/* dv/lcdw_tb_pkg.sv */
package lcdw_tb_pkg;
   import lcdw_pkg::*;

   localparam logic [2:0] ACT_SPARE_LO = 3'd5;
   localparam logic [2:0] ACT_SPARE_HI = 3'd7;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 3'd5;
   localparam int REPORT_LIMIT = 10;

   localparam logic [7:0] BOOT_BYTES [0:6] = '{8'h33, 8'h32, 8'h28, 8'h08, 8'h01, 8'h06, 8'h0C};

   // Tracks the display state item by item and holds the pin levels still owed.
   class lcd_pin_tracker;
      lcdw_cfg_type    timing;
      lcdw_phase_type  phase;
      logic [15:0]     countdown;
      logic [7:0]      cur_byte;
      logic            cur_rs;
      logic [2:0]      boot_idx;
      logic            booting;
      lcdw_pins_type   pins;
      lcdw_result_type pins_due[$];
      int              mismatches;
      int              seen;

      function new();
         timing.enable_high_us = RST_ENABLE_HIGH;
         timing.enable_gap_us  = RST_ENABLE_GAP;
         timing.settle_us      = RST_SETTLE;
         timing.clear_extra_us = RST_CLEAR_EXTRA;
         timing.power_up_us    = RST_POWER_UP;
         phase      = PH_IDLE;
         countdown  = '0;
         cur_byte   = '0;
         cur_rs     = 1'b0;
         boot_idx   = '0;
         booting    = 1'b0;
         pins       = '0;
         mismatches = 0;
         seen       = 0;
      endfunction

      function void set_timing(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_ENABLE_HIGH: timing.enable_high_us = val[7:0];
            CSR_ENABLE_GAP:  timing.enable_gap_us  = val[9:0];
            CSR_SETTLE:      timing.settle_us      = val;
            CSR_CLEAR_EXTRA: timing.clear_extra_us = val;
            CSR_POWER_UP:    timing.power_up_us    = val;
            default: ;
         endcase
      endfunction

      function bit is_busy();
         return phase != PH_IDLE;
      endfunction

      function int pending();
         return pins_due.size();
      endfunction

      function void start_byte(logic [7:0] b, logic rs);
         cur_byte  = b;
         cur_rs    = rs;
         pins      = '{rs: rs, en: 1'b1, nib: b[7:4]};
         phase     = PH_HI_EN;
         countdown = {8'd0, timing.enable_high_us};
      endfunction

      // A finished byte either hands over to the next power-up byte or goes idle.
      function void end_byte();
         if (booting) begin
            boot_idx = boot_idx + 3'd1;
            if (boot_idx < INIT_LEN) begin
               start_byte(BOOT_BYTES[boot_idx], 1'b0);
               return;
            end
            booting = 1'b0;
         end
         phase     = PH_IDLE;
         countdown = '0;
      endfunction

      function void next_step();
         case (phase)
            PH_POWER: begin
               boot_idx = '0;
               start_byte(BOOT_BYTES[0], 1'b0);
            end
            PH_HI_EN: begin
               pins      = '{rs: cur_rs, en: 1'b0, nib: cur_byte[7:4]};
               phase     = PH_HI_GP;
               countdown = {6'd0, timing.enable_gap_us};
            end
            PH_HI_GP: begin
               pins      = '{rs: cur_rs, en: 1'b1, nib: cur_byte[3:0]};
               phase     = PH_LO_EN;
               countdown = {8'd0, timing.enable_high_us};
            end
            PH_LO_EN: begin
               pins      = '{rs: cur_rs, en: 1'b0, nib: cur_byte[3:0]};
               phase     = PH_LO_GP;
               countdown = {6'd0, timing.enable_gap_us};
            end
            PH_LO_GP: begin
               phase     = PH_SETTLE;
               countdown = timing.settle_us;
            end
            PH_SETTLE: begin
               // Only the clear command, not a data byte of the same value, waits longer.
               if (!cur_rs && cur_byte == CLEAR_CMD) begin
                  phase     = PH_CLEAR;
                  countdown = timing.clear_extra_us;
               end else begin
                  end_byte();
               end
            end
            PH_CLEAR: end_byte();
            default: begin
               phase     = PH_IDLE;
               countdown = '0;
            end
         endcase
      endfunction

      function void run_out_zero_waits();
         while (phase != PH_IDLE && countdown == '0) next_step();
      endfunction

      function void take_request(logic [2:0] act, logic [7:0] bv, logic row, logic [5:0] col);
         lcdw_result_type due;
         logic            refused;
         refused = 1'b0;
         case (act)
            ACT_TICK: begin
               if (phase != PH_IDLE) begin
                  if (countdown > 16'd1) begin
                     countdown = countdown - 16'd1;
                  end else begin
                     next_step();
                     run_out_zero_waits();
                  end
               end
            end
            ACT_COMMAND, ACT_DATA, ACT_CURSOR, ACT_INIT: begin
               if (phase != PH_IDLE) begin
                  refused = 1'b1;
               end else begin
                  case (act)
                     ACT_COMMAND: start_byte(bv, 1'b0);
                     ACT_DATA:    start_byte(bv, 1'b1);
                     ACT_CURSOR:  start_byte(CURSOR_CMD | ({2'b00, col} +
                                             (row ? {1'b0, ROW2_OFFSET} : 8'h00)), 1'b0);
                     default: begin
                        booting   = 1'b1;
                        boot_idx  = '0;
                        phase     = PH_POWER;
                        countdown = timing.power_up_us;
                     end
                  endcase
                  run_out_zero_waits();
               end
            end
            default: ;
         endcase
         due.pins     = pins;
         due.busy     = (phase != PH_IDLE);
         due.rejected = refused;
         pins_due.push_back(due);
      endfunction

      function void complain(string msg);
         mismatches++;
         if (mismatches <= REPORT_LIMIT) $display("%s", msg);
      endfunction

      function void match_pins(lcdw_result_type got);
         lcdw_result_type want;
         seen++;
         if (pins_due.size() == 0) begin
            complain($sformatf("result %0d arrived with no item outstanding", seen));
            return;
         end
         want = pins_due.pop_front();
         if (got.pins.rs !== want.pins.rs || got.pins.en !== want.pins.en ||
             got.pins.nib !== want.pins.nib || got.busy !== want.busy ||
             got.rejected !== want.rejected) begin
            complain($sformatf({"result %0d: expected rs=%b en=%b nib=%h busy=%b rej=%b,",
                                " got rs=%b en=%b nib=%h busy=%b rej=%b"}, seen,
                               want.pins.rs, want.pins.en, want.pins.nib, want.busy,
                               want.rejected, got.pins.rs, got.pins.en, got.pins.nib,
                               got.busy, got.rejected));
         end
      endfunction
   endclass

endpackage

/* dv/tb_char_lcd_4bit_write_sequencer.sv */
module tb_char_lcd_4bit_write_sequencer;
   timeunit 1ns;
   timeprecision 1ps;

   import lcdw_pkg::*;
   import lcdw_tb_pkg::*;

   localparam int IDLE_LIMIT      = 2000;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int MAX_GAP         = 10;
   localparam int SETTLE_CYCLES   = 4;
   localparam int ROUND_ITEMS     = 60;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   lcdw_req_if req_bus();
   lcdw_rsp_if rsp_bus();

   lcd_pin_tracker tracker;
   bit             back_to_back;
   bit             want_hold_off;
   int             quiet_cycles = 0;

   char_lcd_4bit_write_sequencer u_top (
      .clock        (clock),
      .reset        (reset),
      .req_port     (req_bus),
      .rsp_port     (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int draw_gap();
      return back_to_back ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   function automatic int small_wait(int top);
      return ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, top);
   endfunction

   task automatic offer(input logic [2:0] act, input logic [7:0] bv = 8'h00,
                        input logic row = 1'b0, input logic [5:0] col = 6'd0);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.action     <= act;
      req_bus.byte_value <= bv;
      req_bus.row        <= row;
      req_bus.col        <= col;
      do @(posedge clock); while (!req_bus.ready);
      tracker.take_request(act, bv, row, col);
   endtask

   // Mostly ticks while a transfer runs and mostly requests while idle.
   task automatic offer_random();
      int         pick;
      int         lim;
      int         kind;
      logic [2:0] act;
      pick = $urandom_range(0, 99);
      lim  = tracker.is_busy() ? 85 : 10;
      if (pick < lim) begin
         act = ACT_TICK;
      end else if (pick < lim + 5) begin
         act = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
      end else begin
         kind = $urandom_range(0, 99);
         act  = (kind < 35) ? ACT_COMMAND : (kind < 65) ? ACT_DATA :
                (kind < 92) ? ACT_CURSOR : ACT_INIT;
      end
      offer(act, 8'($urandom), 1'($urandom), 6'($urandom_range(0, 63)));
   endtask

   task automatic drain_display();
      back_to_back = 1'b1;
      while (tracker.is_busy()) offer(ACT_TICK);
      back_to_back = 1'b0;
   endtask

   task automatic wait_results();
      req_bus.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      tracker.set_timing(idx, val);
   endtask

   task automatic load_timing(input logic [7:0] hi, input logic [9:0] gp,
                              input logic [15:0] st, input logic [15:0] cl,
                              input logic [15:0] pw);
      drain_display();
      wait_results();
      write_csr(CSR_ENABLE_HIGH, {8'd0, hi});
      write_csr(CSR_ENABLE_GAP, {6'd0, gp});
      write_csr(CSR_SETTLE, st);
      write_csr(CSR_CLEAR_EXTRA, cl);
      write_csr(CSR_POWER_UP, pw);
      csr_write_en <= 1'b0;
   endtask

   initial begin
      lcdw_result_type got;
      int              stall;
      bit              held;
      rsp_bus.ready = 1'b0;
      held = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         // One long hold-off lets the queue fill so the input side stalls.
         if (want_hold_off && !held) begin
            stall = HOLD_OFF_CYCLES;
            held  = 1'b1;
         end else begin
            stall = draw_gap();
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         got.pins.rs  = rsp_bus.rs_pin;
         got.pins.en  = rsp_bus.enable_pin;
         got.pins.nib = rsp_bus.bus_nibble;
         got.busy     = rsp_bus.busy_res;
         got.rejected = rsp_bus.rejected;
         tracker.match_pins(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          csr_write_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
         $display("tb_char_lcd_4bit_write_sequencer: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      tracker            = new();
      reset              = 1'b1;
      csr_write_en       = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_bus.valid      = 1'b0;
      req_bus.action     = ACT_TICK;
      req_bus.byte_value = '0;
      req_bus.row        = 1'b0;
      req_bus.col        = '0;
      back_to_back       = 1'b0;
      want_hold_off      = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset timing: a clear command, then requests that arrive while busy.
      offer(ACT_COMMAND, CLEAR_CMD);
      offer(ACT_DATA, 8'hFF);
      offer(ACT_CURSOR, 8'h00, 1'b1, 6'd39);
      offer(ACT_INIT);
      offer(ACT_SPARE_HI);
      offer(ACT_TICK);

      // The settle and clear waits are shortened while the clear command is still
      // in its enable phases, so the rest of its transfer stays brief.
      wait_results();
      write_csr(CSR_SETTLE, 16'd3);
      write_csr(CSR_CLEAR_EXTRA, 16'd2);
      csr_write_en <= 1'b0;

      // With every wait at zero each request completes within its own item.
      load_timing(8'd0, 10'd0, 16'd0, 16'd0, 16'd0);
      offer(ACT_TICK);
      offer(ACT_INIT);
      offer(ACT_COMMAND, 8'h00);
      offer(ACT_DATA, CLEAR_CMD);
      offer(ACT_CURSOR, 8'h00, 1'b1, 6'd63);
      offer(ACT_CURSOR, 8'hFF, 1'b0, 6'd0);
      offer(ACT_DATA, 8'hA5);

      // Only the clear wait is left, so power-up comes to rest on the clear command.
      load_timing(8'd0, 10'd0, 16'd0, 16'd3, 16'd0);
      offer(ACT_INIT);
      drain_display();
      offer(ACT_COMMAND, CLEAR_CMD);
      offer(ACT_DATA, CLEAR_CMD);
      drain_display();
      offer(ACT_DATA, CLEAR_CMD);

      // Upper data bits beyond a register's width are dropped; a spare index is ignored.
      load_timing(8'd2, 10'd1, 16'd2, 16'd1, 16'd3);
      write_csr(CSR_ENABLE_HIGH, 16'hFF02);
      write_csr(CSR_ENABLE_GAP, 16'hFC01);
      write_csr(CSR_SPARE, 16'hFFFF);
      csr_write_en <= 1'b0;
      offer(ACT_INIT);
      offer(ACT_SPARE_LO);
      offer(ACT_COMMAND, 8'h28);

      repeat (5) begin
         load_timing(8'(small_wait(3)), 10'(small_wait(3)), 16'(small_wait(6)),
                     16'(small_wait(4)), 16'(small_wait(5)));
         want_hold_off = 1'b1;
         repeat (ROUND_ITEMS) offer_random();
      end

      // Longest value in every register; the power-up wait holds while requests
      // are refused, and the run ends with the display still busy.
      load_timing(8'hFF, 10'h3FF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      offer(ACT_INIT);
      repeat (3) offer(ACT_TICK);
      offer(ACT_COMMAND, CLEAR_CMD);
      offer(ACT_DATA, 8'h5A);

      wait_results();
      repeat (10) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("tb_char_lcd_4bit_write_sequencer: PASS");
      end else begin
         $display("tb_char_lcd_4bit_write_sequencer: FAIL");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+src
src/lcdw_pkg.sv
src/lcdw_if.sv
src/lcdw_front.sv
src/lcdw_queue.sv
src/lcdw_back.sv
src/char_lcd_4bit_write_sequencer.sv
dv/lcdw_tb_pkg.sv
dv/tb_char_lcd_4bit_write_sequencer.sv
